// ----- hdl/ecd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared types, codes and search helpers of the elevator dispatcher.
// ----------------------------------------------------------------------------
package ecd_pkg;

   localparam int MAX_FLOORS = 16;
   localparam int FLOOR_W    = $clog2(MAX_FLOORS);
   localparam int COUNT_W    = 5;
   localparam int LOAD_W     = 16;
   localparam int TIMER_W    = 17;
   localparam int ELAPSED_W  = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 64;

   localparam logic [COUNT_W-1:0] FLOOR_COUNT_RESET = COUNT_W'(16);
   localparam logic [LOAD_W-1:0]  LOAD_TIME_RESET   = LOAD_W'(100);
   localparam logic [COUNT_W-1:0] FLOORS_MIN        = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] FLOORS_MAX        = COUNT_W'(MAX_FLOORS);
   localparam logic [TIMER_W-1:0] TIMER_MAX         = {TIMER_W{1'b1}};

   typedef logic [MAX_FLOORS-1:0] mask_type;
   typedef logic [FLOOR_W-1:0]    floor_type;

   typedef enum logic [2:0] {
      CMD_TICK        = 3'd0,
      CMD_SUMMON_UP   = 3'd1,
      CMD_SUMMON_DOWN = 3'd2,
      CMD_CABIN       = 3'd3,
      CMD_ARRIVE      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLOOR_COUNT = 1'd0,
      CSR_LOAD_TIME   = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [ELAPSED_W-1:0] elapsed;
      floor_type            floor;
      logic [2:0]           cmd;
   } req_item_type;

   typedef struct packed {
      mask_type  down_lamps;
      mask_type  up_lamps;
      mask_type  cabin_lamps;
      logic      loading;
      floor_type current_floor;
      logic [1:0] route;
      floor_type target_floor;
      logic      move_cmd;
   } rsp_item_type;

   typedef struct packed {
      logic      hit;
      floor_type idx;
   } search_type;

   // selector verdict; clr_* drop the car's own summon bit
   typedef struct packed {
      logic      move;
      floor_type target;
      dir_type   dir;
      logic      clr_up;
      logic      clr_down;
   } sel_type;

   function automatic search_type lowest_set(input mask_type m);
      search_type r;
      r = '0;
      for (int i = MAX_FLOORS - 1; i >= 0; i--) begin
         if (m[i]) begin
            r.hit = 1'b1;
            r.idx = FLOOR_W'(i);
         end
      end
      return r;
   endfunction

   function automatic search_type highest_set(input mask_type m);
      search_type r;
      r = '0;
      for (int i = 0; i < MAX_FLOORS; i++) begin
         if (m[i]) begin
            r.hit = 1'b1;
            r.idx = FLOOR_W'(i);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/ecd_target_select.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ecd_target_select
// Collective target search: ahead along the route, then the far end for the
// opposite summons, then once reversed; idle car takes the lowest request.
// ----------------------------------------------------------------------------
module ecd_target_select (
   input  wire ecd_pkg::mask_type            cabin_req,
   input  wire ecd_pkg::mask_type            up_req,
   input  wire ecd_pkg::mask_type            down_req,
   input  wire ecd_pkg::floor_type           at_floor,
   input  wire ecd_pkg::dir_type             travel_dir,
   input  wire [ecd_pkg::COUNT_W-1:0]        floors_used,
   output ecd_pkg::sel_type                  sel
);

   ecd_pkg::mask_type   in_use;
   ecd_pkg::mask_type   above;
   ecd_pkg::mask_type   below;
   ecd_pkg::mask_type   cur_bit;
   logic                cur_lt_n;
   logic                cur_le_n;
   ecd_pkg::search_type idle_s;
   ecd_pkg::search_type up_ahead;
   ecd_pkg::search_type up_far;
   ecd_pkg::search_type dn_ahead;
   ecd_pkg::search_type dn_far;
   ecd_pkg::search_type up_s;
   ecd_pkg::search_type dn_s;
   ecd_pkg::search_type pick;
   logic                reversed;

   always_comb begin
      for (int i = 0; i < ecd_pkg::MAX_FLOORS; i++) begin
         in_use[i]  = ecd_pkg::COUNT_W'(i) < floors_used;
         above[i]   = ecd_pkg::FLOOR_W'(i) > at_floor;
         below[i]   = ecd_pkg::FLOOR_W'(i) < at_floor;
         cur_bit[i] = ecd_pkg::FLOOR_W'(i) == at_floor;
      end
      cur_lt_n = {1'b0, at_floor} < floors_used;
      cur_le_n = {1'b0, at_floor} <= floors_used;

      idle_s   = ecd_pkg::lowest_set((cabin_req | up_req | down_req) & in_use & ~cur_bit);

      // upward pass
      up_ahead = ecd_pkg::lowest_set((cabin_req | up_req) & above & in_use);
      up_far   = ecd_pkg::highest_set(down_req & (cur_lt_n ? (above & in_use) : in_use));
      up_s     = up_ahead.hit ? up_ahead : up_far;

      // downward pass; a car more than one floor above the floors in use sees nothing ahead
      dn_ahead = ecd_pkg::highest_set((cabin_req | down_req) & (cur_le_n ? below : '0));
      dn_far   = ecd_pkg::lowest_set(up_req & below & in_use);
      dn_s     = dn_ahead.hit ? dn_ahead : dn_far;

      reversed = 1'b0;
      case (travel_dir)
         ecd_pkg::DIR_UP: begin
            pick     = up_s.hit ? up_s : dn_s;
            reversed = !up_s.hit;
         end
         ecd_pkg::DIR_DOWN: begin
            pick     = dn_s.hit ? dn_s : up_s;
            reversed = !dn_s.hit;
         end
         default: begin
            pick = idle_s;
         end
      endcase

      if (!pick.hit) begin
         sel.move     = 1'b0;
         sel.target   = at_floor;
         sel.dir      = ecd_pkg::DIR_NONE;
         sel.clr_up   = 1'b1;
         sel.clr_down = 1'b1;
      end else begin
         sel.move     = 1'b1;
         sel.target   = pick.idx;
         sel.dir      = (pick.idx > at_floor) ? ecd_pkg::DIR_UP : ecd_pkg::DIR_DOWN;
         // after turning round, the summon for the new direction here is served
         sel.clr_down = reversed && (travel_dir == ecd_pkg::DIR_UP);
         sel.clr_up   = reversed && (travel_dir == ecd_pkg::DIR_DOWN);
      end
   end

endmodule
`default_nettype wire

// ----- hdl/ecd_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ecd_core
// Dispatcher state, configuration registers and the per-command update.
// ----------------------------------------------------------------------------
module ecd_core (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               fire,
   input  wire ecd_pkg::req_item_type        item,
   input  wire                               csr_we,
   input  wire [ecd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [ecd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ecd_pkg::rsp_item_type             result
);

   ecd_pkg::mask_type               cabin_ff, cabin_in;
   ecd_pkg::mask_type               up_ff, up_in;
   ecd_pkg::mask_type               down_ff, down_in;
   ecd_pkg::floor_type              floor_ff, floor_in;
   ecd_pkg::dir_type                dir_ff, dir_in;
   logic                            loading_ff, loading_in;
   logic [ecd_pkg::TIMER_W-1:0]     timer_ff, timer_in;
   logic [ecd_pkg::COUNT_W-1:0]     floor_count_ff;
   logic [ecd_pkg::LOAD_W-1:0]      load_time_ff;

   logic [ecd_pkg::COUNT_W-1:0]     floors_used;
   logic                            valid_floor;
   ecd_pkg::mask_type               req_bit;
   ecd_pkg::mask_type               cabin_set, up_set, down_set;
   ecd_pkg::mask_type               cur_bit;
   logic                            do_sel;
   logic [ecd_pkg::TIMER_W:0]       timer_sum;
   ecd_pkg::sel_type                sel;

   always_comb begin
      if (floor_count_ff < ecd_pkg::FLOORS_MIN) begin
         floors_used = ecd_pkg::FLOORS_MIN;
      end else if (floor_count_ff > ecd_pkg::FLOORS_MAX) begin
         floors_used = ecd_pkg::FLOORS_MAX;
      end else begin
         floors_used = floor_count_ff;
      end
      valid_floor = {1'b0, item.floor} < floors_used;
      req_bit     = ecd_pkg::mask_type'(1) << item.floor;
      cur_bit     = ecd_pkg::mask_type'(1) << floor_ff;

      cabin_set = cabin_ff;
      up_set    = up_ff;
      down_set  = down_ff;
      if (valid_floor) begin
         case (item.cmd)
            ecd_pkg::CMD_SUMMON_UP:   up_set    = up_ff | req_bit;
            ecd_pkg::CMD_SUMMON_DOWN: down_set  = down_ff | req_bit;
            ecd_pkg::CMD_CABIN:       cabin_set = cabin_ff | req_bit;
            default: ;
         endcase
      end
   end

   ecd_target_select u_select (
      .cabin_req   (cabin_set),
      .up_req      (up_set),
      .down_req    (down_set),
      .at_floor    (floor_ff),
      .travel_dir  (dir_ff),
      .floors_used (floors_used),
      .sel         (sel)
   );

   always_comb begin
      cabin_in   = cabin_set;
      up_in      = up_set;
      down_in    = down_set;
      floor_in   = floor_ff;
      dir_in     = dir_ff;
      loading_in = loading_ff;
      timer_in   = timer_ff;
      do_sel     = 1'b0;
      timer_sum  = {1'b0, timer_ff} + (ecd_pkg::TIMER_W + 1)'(item.elapsed);

      case (item.cmd)
         ecd_pkg::CMD_TICK: begin
            if (loading_ff) begin
               if (timer_ff > {1'b0, load_time_ff}) begin
                  loading_in = 1'b0;
                  do_sel     = 1'b1;
               end else if (timer_sum[ecd_pkg::TIMER_W]) begin
                  timer_in = ecd_pkg::TIMER_MAX;
               end else begin
                  timer_in = timer_sum[ecd_pkg::TIMER_W-1:0];
               end
            end
         end
         ecd_pkg::CMD_SUMMON_UP, ecd_pkg::CMD_SUMMON_DOWN, ecd_pkg::CMD_CABIN: begin
            do_sel = valid_floor;
         end
         ecd_pkg::CMD_ARRIVE: begin
            if (valid_floor && item.floor != floor_ff) begin
               floor_in = item.floor;
               cabin_in = cabin_ff & ~req_bit;
               if (dir_ff == ecd_pkg::DIR_UP || dir_ff == ecd_pkg::DIR_NONE) begin
                  up_in = up_ff & ~req_bit;
               end
               if (dir_ff == ecd_pkg::DIR_DOWN || dir_ff == ecd_pkg::DIR_NONE) begin
                  down_in = down_ff & ~req_bit;
               end
               if (!loading_ff) begin
                  loading_in = 1'b1;
                  timer_in   = '0;
               end
            end
         end
         default: ;
      endcase

      if (do_sel) begin
         dir_in = sel.dir;
         if (sel.clr_up) begin
            up_in = up_set & ~cur_bit;
         end
         if (sel.clr_down) begin
            down_in = down_set & ~cur_bit;
         end
      end

      result.move_cmd      = do_sel && sel.move;
      result.target_floor  = (do_sel && sel.move) ? sel.target : floor_in;
      result.route         = dir_in;
      result.current_floor = floor_in;
      result.loading       = loading_in;
      result.cabin_lamps   = cabin_in;
      result.up_lamps      = up_in;
      result.down_lamps    = down_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cabin_ff   <= '0;
         up_ff      <= '0;
         down_ff    <= '0;
         floor_ff   <= '0;
         dir_ff     <= ecd_pkg::DIR_NONE;
         loading_ff <= 1'b0;
         timer_ff   <= '0;
      end else if (fire) begin
         cabin_ff   <= cabin_in;
         up_ff      <= up_in;
         down_ff    <= down_in;
         floor_ff   <= floor_in;
         dir_ff     <= dir_in;
         loading_ff <= loading_in;
         timer_ff   <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_count_ff <= ecd_pkg::FLOOR_COUNT_RESET;
         load_time_ff   <= ecd_pkg::LOAD_TIME_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ecd_pkg::CSR_FLOOR_COUNT: floor_count_ff <= csr_wdata[ecd_pkg::COUNT_W-1:0];
            ecd_pkg::CSR_LOAD_TIME:   load_time_ff   <= csr_wdata[ecd_pkg::LOAD_W-1:0];
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- hdl/elevator_collective_dispatch_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// elevator_collective_dispatch_top
// Directional collective elevator dispatcher with stream in and out.
// ----------------------------------------------------------------------------
// One command in, one status result out. A command is held in an input
// register and, once the result register is free or rsp_tready is high, the
// whole update (request masks, loading timer and the target search over
// the floor masks) is done in one pass into the result register, so the
// block takes one transaction per clock cycle while rsp_tready is high;
// a result is offered on rsp_tvalid from the result register. While a
// result waits on rsp_tready the input register can still take one
// command; after that req_tready follows rsp_tready. Configuration writes
// land at once; make them only when no command is in flight.
module elevator_collective_dispatch_top (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // [2:0] cmd, [6:3] floor, [14:7] elapsed, [15] unused
   input  wire [ecd_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // [0] move_cmd, [4:1] target_floor, [6:5] route, [10:7] current_floor,
   // [11] loading, [27:12] cabin_lamps, [43:28] up_lamps,
   // [59:44] down_lamps, [63:60] zero
   output logic [ecd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire                               csr_we,
   input  wire [ecd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [ecd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                   in_valid_ff;
   ecd_pkg::req_item_type  in_item_ff;
   logic                   out_valid_ff;
   ecd_pkg::rsp_item_type  out_item_ff;
   ecd_pkg::rsp_item_type  result;
   logic                   fire;

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(ecd_pkg::RSP_DATA_W - $bits(ecd_pkg::rsp_item_type)){1'b0}},
                        out_item_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_tdata[$bits(ecd_pkg::req_item_type)-1:0];
      end
   end

   ecd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_item_ff),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_item_ff <= result;
      end
   end

endmodule
`default_nettype wire
